// ===== rtl/wall_distance_search_macros.svh =====
// Assertion macros for the wall distance search block.
// Needs nothing else; the asserting files include it by name.
`ifndef WALL_DISTANCE_SEARCH_MACROS_SVH
`define WALL_DISTANCE_SEARCH_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked at every rising edge outside reset
`define WDS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wall_distance_search: check failed");
// Next-cycle implication
`define WDS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wall_distance_search: check failed");
`else
`define WDS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define WDS_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/wds_pkg.sv =====
// Shared types and codes for the wall distance search block.
// Depends on nothing.
package wds_pkg;

   // Fixed field widths of the words
   localparam int unsigned COORD_W  = 32;
   localparam int unsigned DIST_W   = 32;
   localparam int unsigned HELD_W   = 11;
   localparam int unsigned SQR_W    = 2 * DIST_W;
   localparam int unsigned SQRT_STEPS = DIST_W;
   localparam int unsigned STEP_W   = $clog2(SQRT_STEPS);

   // Item modes
   localparam logic [1:0] MODE_APPEND = 2'd0;
   localparam logic [1:0] MODE_QUERY  = 2'd1;
   localparam logic [1:0] MODE_CLEAR  = 2'd2;

   // Result status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;

   typedef struct packed {
      logic [1:0]         mode;
      logic [COORD_W-1:0] coord_x;
      logic [COORD_W-1:0] coord_y;
   } req_word_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic [1:0]        status;
      logic [HELD_W-1:0] points_held;
   } rsp_word_type;

endpackage

// ===== rtl/wall_distance_search.sv =====
// Top level of the wall distance search block: point table memory, scan
// pipeline and bit-serial square root. Depends on wds_pkg and the macro header.
//
// Usage:
//   Input words are taken on req_word at a rising edge where start is high
//   and busy is low. mode appends a wall point, clears the table, queries the
//   nearest distance, or (unused code) does nothing.
//   Every accepted word gives exactly one result word on rsp_word, shown for
//   one cycle with rsp_strobe high. The receiver cannot hold results off.
//   Append, clear, no-op and a query on an empty table: result in the cycle
//   after acceptance, and busy stays low, so words may follow back to back.
//   Query on N stored points: the memory is read once per point, one point
//   per cycle, through a three-stage distance pipeline, then a 32-step square
//   root runs one result bit per cycle. busy is high from acceptance until
//   the result appears.
//   Reset clears the point count, the control state and the result strobe;
//   the point memory is left as is, since only written entries are read.
`include "wall_distance_search_macros.svh"

module wall_distance_search
   import wds_pkg::*;
#(
   parameter int unsigned WALL_POINTS = 1024,
   parameter int unsigned COORD_BITS  = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         rsp_strobe,
   output rsp_word_type rsp_word
);

   localparam int unsigned CNT_W  = $clog2(WALL_POINTS + 1);
   localparam int unsigned ADDR_W = (WALL_POINTS > 1) ? $clog2(WALL_POINTS) : 1;
   localparam int unsigned ENTRY_W = 2 * COORD_BITS;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_ROOT  = 4'b1000
   } state_type;

   // Control
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   rd_cnt_ff, rd_cnt_in;
   logic               accept;
   logic               issue;
   logic               v1_ff, v2_ff, v3_ff;

   // Memory and datapath
   logic [ENTRY_W-1:0] wall_mem [WALL_POINTS];
   logic [ENTRY_W-1:0] rd_word_ff;
   logic [COORD_BITS-1:0] qx_ff, qy_ff;
   logic [DIST_W-1:0]  dx_ff, dy_ff;
   logic [SQR_W-1:0]   sqx_ff, sqy_ff;
   logic [SQR_W-1:0]   best_ff;
   logic [SQR_W:0]     sum_wide;
   logic [SQR_W-1:0]   sum_sat;

   // Square root
   logic [SQR_W-1:0]   root_val_ff;
   logic [DIST_W+1:0]  rem_ff, rem_in;
   logic [DIST_W-1:0]  root_ff, root_in;
   logic [STEP_W-1:0]  step_ff;
   logic [DIST_W+1:0]  rem_sh;
   logic [DIST_W+1:0]  trial;

   // Result
   logic               rsp_strobe_ff;
   rsp_word_type       rsp_word_ff;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);
   assign issue  = (state_ff == ST_SCAN);

   // Difference magnitude of two sign-extended coordinates
   function automatic logic [DIST_W-1:0] coord_dist(input logic [COORD_BITS-1:0] a,
                                                    input logic [COORD_BITS-1:0] b);
      logic signed [COORD_BITS:0] ea;
      logic signed [COORD_BITS:0] eb;
      logic signed [COORD_BITS:0] d;
      logic        [COORD_BITS:0] m;
      ea = {a[COORD_BITS-1], a};
      eb = {b[COORD_BITS-1], b};
      d  = ea - eb;
      m  = d[COORD_BITS] ? (~d + 1'b1) : d;
      return DIST_W'(m[COORD_BITS-1:0]);
   endfunction

   // Sequencer: scan, drain the pipeline, then root
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      rd_cnt_in = rd_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_word.mode)
                  MODE_APPEND: begin
                     if (count_ff != CNT_W'(WALL_POINTS)) begin
                        count_in = count_ff + 1'b1;
                     end
                  end
                  MODE_QUERY: begin
                     if (count_ff != '0) begin
                        state_in  = ST_SCAN;
                        rd_cnt_in = '0;
                     end
                  end
                  MODE_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            rd_cnt_in = rd_cnt_ff + 1'b1;
            if (rd_cnt_ff == count_ff - 1'b1) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!v1_ff && !v2_ff && !v3_ff) begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (step_ff == STEP_W'(SQRT_STEPS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         rd_cnt_ff <= '0;
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rd_cnt_ff <= rd_cnt_in;
         v1_ff     <= issue;
         v2_ff     <= v1_ff;
         v3_ff     <= v2_ff;
      end
   end

   // Point memory: write on append, read one entry per scan cycle
   always_ff @(posedge clock) begin
      if (accept && (req_word.mode == MODE_APPEND) &&
          (count_ff != CNT_W'(WALL_POINTS))) begin
         wall_mem[count_ff[ADDR_W-1:0]] <= {req_word.coord_x[COORD_BITS-1:0],
                                            req_word.coord_y[COORD_BITS-1:0]};
      end
      if (issue) begin
         rd_word_ff <= wall_mem[rd_cnt_ff[ADDR_W-1:0]];
      end
   end

   // Squared sum, saturated at the top of the range
   assign sum_wide = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign sum_sat  = sum_wide[SQR_W] ? '1 : sum_wide[SQR_W-1:0];

   // Distance pipeline: difference, square, running minimum
   always_ff @(posedge clock) begin
      if (accept) begin
         qx_ff   <= req_word.coord_x[COORD_BITS-1:0];
         qy_ff   <= req_word.coord_y[COORD_BITS-1:0];
         best_ff <= '1;
      end
      if (v1_ff) begin
         dx_ff <= coord_dist(qx_ff, rd_word_ff[ENTRY_W-1:COORD_BITS]);
         dy_ff <= coord_dist(qy_ff, rd_word_ff[COORD_BITS-1:0]);
      end
      if (v2_ff) begin
         sqx_ff <= dx_ff * dx_ff;
         sqy_ff <= dy_ff * dy_ff;
      end
      if (v3_ff && (sum_sat < best_ff)) begin
         best_ff <= sum_sat;
      end
   end

   // Square root step: bring down two bits, try to subtract
   assign rem_sh = {rem_ff[DIST_W-1:0], root_val_ff[SQR_W-1:SQR_W-2]};
   assign trial  = {root_ff, 2'b01};

   always_comb begin
      if (rem_sh >= trial) begin
         rem_in  = rem_sh - trial;
         root_in = {root_ff[DIST_W-2:0], 1'b1};
      end else begin
         rem_in  = rem_sh;
         root_in = {root_ff[DIST_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DRAIN) begin
         root_val_ff <= best_ff;
         rem_ff      <= '0;
         root_ff     <= '0;
         step_ff     <= '0;
      end else if (state_ff == ST_ROOT) begin
         root_val_ff <= {root_val_ff[SQR_W-3:0], 2'b00};
         rem_ff      <= rem_in;
         root_ff     <= root_in;
         step_ff     <= step_ff + 1'b1;
      end
   end

   // Result word: registered alongside the strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= (accept && !((req_word.mode == MODE_QUERY) && (count_ff != '0)))
                          || ((state_ff == ST_ROOT) && (step_ff == STEP_W'(SQRT_STEPS - 1)));
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_word_ff.distance    <= '0;
         rsp_word_ff.status      <= STAT_OK;
         rsp_word_ff.points_held <= HELD_W'(count_in);
         case (req_word.mode)
            MODE_APPEND: begin
               if (count_ff == CNT_W'(WALL_POINTS)) begin
                  rsp_word_ff.status <= STAT_FULL;
               end
            end
            MODE_QUERY: begin
               if (count_ff == '0) begin
                  rsp_word_ff.distance <= '1;
                  rsp_word_ff.status   <= STAT_EMPTY;
               end
            end
            default: begin
            end
         endcase
      end else if ((state_ff == ST_ROOT) && (step_ff == STEP_W'(SQRT_STEPS - 1))) begin
         rsp_word_ff.distance    <= root_in;
         rsp_word_ff.status      <= STAT_OK;
         rsp_word_ff.points_held <= HELD_W'(count_ff);
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   // Checks
   `WDS_ASSERT_IMP(a_count_range, clock, reset, 1'b1, count_ff <= CNT_W'(WALL_POINTS))
   `WDS_ASSERT_IMP(a_scan_in_table, clock, reset, state_ff == ST_SCAN, rd_cnt_ff < count_ff)
   `WDS_ASSERT_IMP(a_root_after_drain, clock, reset, state_ff == ST_ROOT, !v1_ff && !v2_ff && !v3_ff)
   `WDS_ASSERT_IMP(a_strobe_idle_pipe, clock, reset, rsp_strobe_ff, !v1_ff && !v2_ff && !v3_ff)
   `WDS_ASSERT_NXT(a_query_scans, clock, reset, accept && (req_word.mode == MODE_QUERY) && (count_ff != '0), (state_ff == ST_SCAN) && !rsp_strobe_ff)

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for wall_distance_search: drives append, query, clear and no-op words,
// predicts every result word and compares it field by field. Depends on wds_pkg and the RTL.
module testbench
   import wds_pkg::*;
();

   localparam int unsigned WALL_POINTS = 1024;
   localparam int unsigned ITEM_GOAL   = 580;
   localparam int unsigned QUIET_TAIL  = 40;
   localparam int unsigned SETTLE_CYCLES = 80;
   localparam logic [1:0]  MODE_NOP    = 2'd3;

   typedef struct {
      req_word_type word;
      bit           hold_until_drained;
   } pending_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_word_type req_word = '0;
   logic         rsp_strobe;
   rsp_word_type rsp_word;

   // Stimulus backlog and results still owed by the block
   pending_type  word_backlog[$];
   rsp_word_type due_results[$];

   // Predictor state: own copy of the wall point store
   logic [COORD_W-1:0] wall_x_copy [WALL_POINTS];
   logic [COORD_W-1:0] wall_y_copy [WALL_POINTS];
   int unsigned        held_points = 0;

   int unsigned error_count = 0;
   int unsigned gap_left = 0;
   logic        word_taken = 1'b0;
   bit          hold_next = 1'b0;
   int unsigned item_total = 0;
   int unsigned gen_held = 0;
   int unsigned n_append = 0, n_dropped = 0, n_query = 0, n_empty = 0;
   int unsigned n_saturated = 0, n_clear = 0, n_nop = 0;

   wall_distance_search dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // Floor of the square root of an unsigned Q64.0 value, one result bit per trial
   function automatic logic [DIST_W-1:0] floor_root(logic [SQR_W-1:0] value);
      logic [DIST_W-1:0] root;
      logic [DIST_W-1:0] trial;
      root = '0;
      for (int b = DIST_W - 1; b >= 0; b--) begin
         trial = root | (32'd1 << b);
         if ({32'd0, trial} * {32'd0, trial} <= value) root = trial;
      end
      return root;
   endfunction

   // Apply one word to the point store and work out the result word it gives
   function automatic rsp_word_type nearest_wall_result(req_word_type w);
      rsp_word_type       r;
      logic signed [32:0] dx, dy;
      logic [31:0]        ax, ay;
      logic [SQR_W-1:0]   sqx, sqy, best;
      logic [SQR_W:0]     sq_sum;
      r = '0;
      case (w.mode)
         MODE_APPEND: begin
            n_append++;
            if (held_points < WALL_POINTS) begin
               wall_x_copy[held_points] = w.coord_x;
               wall_y_copy[held_points] = w.coord_y;
               held_points++;
            end else begin
               r.status = STAT_FULL;
               n_dropped++;
            end
         end
         MODE_QUERY: begin
            n_query++;
            if (held_points == 0) begin
               r.distance = '1;
               r.status   = STAT_EMPTY;
               n_empty++;
            end else begin
               best = '1;
               for (int unsigned k = 0; k < held_points; k++) begin
                  dx = $signed({w.coord_x[31], w.coord_x})
                     - $signed({wall_x_copy[k][31], wall_x_copy[k]});
                  dy = $signed({w.coord_y[31], w.coord_y})
                     - $signed({wall_y_copy[k][31], wall_y_copy[k]});
                  ax = (dx < 0) ? 32'(-dx) : 32'(dx);
                  ay = (dy < 0) ? 32'(-dy) : 32'(dy);
                  sqx = {32'd0, ax} * {32'd0, ax};
                  sqy = {32'd0, ay} * {32'd0, ay};
                  sq_sum = {1'b0, sqx} + {1'b0, sqy};
                  // saturate the squared sum at the unsigned Q64.0 maximum
                  if (sq_sum[SQR_W]) sq_sum[SQR_W-1:0] = '1;
                  if (sq_sum[SQR_W-1:0] < best) best = sq_sum[SQR_W-1:0];
               end
               r.distance = floor_root(best);
               if (r.distance == '1) n_saturated++;
            end
         end
         MODE_CLEAR: begin
            held_points = 0;
            n_clear++;
         end
         default: n_nop++;
      endcase
      r.points_held = held_points[HELD_W-1:0];
      return r;
   endfunction

   // Driver: hold a word until taken, then move on, with random idle bursts
   always @(negedge clock) begin : drive_words
      logic         next_start;
      req_word_type next_word;
      pending_type  head;
      next_start = start;
      next_word  = req_word;
      if (reset) begin
         next_start = 1'b0;
      end else if (!(start && !word_taken)) begin
         next_start = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (word_backlog.size() > 0) begin
            if (!word_backlog[0].hold_until_drained || (due_results.size() == 0 && !busy)) begin
               head = word_backlog.pop_front();
               next_start = 1'b1;
               next_word  = head.word;
               if (word_backlog.size() > QUIET_TAIL && $urandom_range(0, 7) == 0)
                  gap_left = $urandom_range(1, 15);
            end
         end
      end
      start    <= next_start;
      req_word <= next_word;
   end

   // Monitor: check each result word, then predict for a word taken at this edge
   always @(posedge clock) begin : check_words
      rsp_word_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            if (due_results.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("%0t: result word with none pending: distance %h status %0d held %0d",
                           $realtime, rsp_word.distance, rsp_word.status, rsp_word.points_held);
            end else begin
               want = due_results.pop_front();
               if (rsp_word.distance !== want.distance || rsp_word.status !== want.status
                   || rsp_word.points_held !== want.points_held) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("%0t: result error: distance %h/%h status %0d/%0d held %0d/%0d %s",
                              $realtime, want.distance, rsp_word.distance, want.status,
                              rsp_word.status, want.points_held, rsp_word.points_held,
                              "(expected/actual)");
               end
            end
         end
         if (start && !busy) due_results.push_back(nearest_wall_result(req_word));
      end
      word_taken <= !reset && start && !busy;
   end

   // Random coordinate: full range, near a centre, or an extreme
   function automatic logic [31:0] rand_coord(logic [31:0] centre);
      case ($urandom_range(0, 7))
         0, 1: return $urandom();
         2: return centre + $urandom_range(0, 255) - 128;
         7: begin
            case ($urandom_range(0, 3))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         default: return centre + $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      endcase
   endfunction

   task automatic queue_word(logic [1:0] mode, logic [31:0] x, logic [31:0] y);
      pending_type p;
      p.word.mode    = mode;
      p.word.coord_x = x;
      p.word.coord_y = y;
      p.hold_until_drained = hold_next;
      hold_next = 1'b0;
      word_backlog.push_back(p);
      item_total++;
      if (mode == MODE_APPEND && gen_held < WALL_POINTS) gen_held++;
      if (mode == MODE_CLEAR) gen_held = 0;
   endtask

   initial begin : stimulus
      logic [31:0] centre;
      int unsigned n_pts, n_queries, fill_words;
      int unsigned phase_no;
      bit          filled;
      fill_words = 0;
      filled     = 1'b0;
      phase_no   = 0;

      // Directed words: empty table, extremes, saturation, rounding, no-op, clear
      queue_word(MODE_QUERY,  32'h0000_0000, 32'h0000_0000);
      queue_word(MODE_NOP,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_word(MODE_CLEAR,  32'h0000_0000, 32'h0000_0000);
      queue_word(MODE_APPEND, 32'h8000_0000, 32'h8000_0000);
      queue_word(MODE_QUERY,  32'h7FFF_FFFF, 32'h7FFF_FFFF);
      queue_word(MODE_QUERY,  32'h8000_0000, 32'h8000_0000);
      queue_word(MODE_APPEND, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      queue_word(MODE_QUERY,  32'h7FFF_FFFF, 32'h8000_0000);
      queue_word(MODE_APPEND, 32'h0000_0000, 32'h0000_0000);
      queue_word(MODE_QUERY,  32'h0000_0001, 32'h0000_0001);
      queue_word(MODE_QUERY,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_word(MODE_APPEND, 32'h0001_0000, 32'hFFFF_0000);
      queue_word(MODE_QUERY,  32'h0001_0003, 32'hFFFF_0004);
      queue_word(MODE_QUERY,  32'h0000_8000, 32'h0000_8000);
      queue_word(MODE_NOP,    32'h1234_5678, 32'h9ABC_DEF0);
      queue_word(MODE_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_word(MODE_QUERY,  32'h0000_0000, 32'h0000_0000);
      queue_word(MODE_APPEND, 32'h4000_0000, 32'hC000_0000);
      queue_word(MODE_QUERY,  32'hC000_0000, 32'h4000_0000);

      // Random phases: build a small point set, then query it, with noise
      while (item_total < ITEM_GOAL + fill_words) begin
         centre = ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom();
         if (phase_no == 0 || $urandom_range(0, 4) == 0) hold_next = 1'b1;
         if (!filled && item_total > ITEM_GOAL / 2) begin
            // fill the store, overrun it, then query the full store
            filled = 1'b1;
            hold_next = 1'b1;
            fill_words = item_total;
            queue_word(MODE_CLEAR, $urandom(), $urandom());
            for (int unsigned i = 0; i < WALL_POINTS + 3; i++)
               queue_word(MODE_APPEND, rand_coord(centre), rand_coord(centre));
            queue_word(MODE_QUERY, centre, centre);
            queue_word(MODE_QUERY, $urandom(), $urandom());
            queue_word(MODE_QUERY, 32'h8000_0000, 32'h7FFF_FFFF);
            queue_word(MODE_CLEAR, $urandom(), $urandom());
            fill_words = item_total - fill_words;
         end
         if (gen_held > 60 || $urandom_range(0, 5) != 0)
            queue_word(MODE_CLEAR, $urandom(), $urandom());
         n_pts = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(0, 12);
         for (int unsigned i = 0; i < n_pts; i++) begin
            case ($urandom_range(0, 9))
               0: queue_word(MODE_QUERY, rand_coord(centre), rand_coord(centre));
               1: queue_word(2'($urandom_range(0, 3)), $urandom(), $urandom());
               default: queue_word(MODE_APPEND, rand_coord(centre), rand_coord(centre));
            endcase
         end
         n_queries = $urandom_range(1, 6);
         for (int unsigned i = 0; i < n_queries; i++) begin
            if ($urandom_range(0, 7) == 0)
               queue_word(($urandom_range(0, 1) == 0) ? MODE_NOP : MODE_CLEAR,
                          $urandom(), $urandom());
            queue_word(MODE_QUERY, rand_coord(centre), rand_coord(centre));
         end
         phase_no++;
      end

      // Drain: all words taken, all results in, then let the block settle
      do @(posedge clock);
      while (reset || word_backlog.size() != 0 || start || due_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d words in %0d phases: %0d appends (%0d dropped on a full store),",
               item_total, phase_no, n_append, n_dropped);
      $display("  %0d queries (%0d on an empty store, %0d at maximum distance),",
               n_query, n_empty, n_saturated);
      $display("  %0d clears, %0d no-ops", n_clear, n_nop);
      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Guard against a hung handshake
   initial begin
      #1_000_000;
      $display("Timeout with %0d results still owed", due_results.size());
      $display("Mismatches found");
      $finish;
   end

endmodule
